// ===== src/afe_pkg.sv =====
// ============================================================================
// afe_pkg
// Shared types, constants and the exponential curve table of the fade unit.
// ============================================================================
`default_nettype none

package afe_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int EXP_TABLE_BITS = 8;

    localparam int GAIN_W  = 25;                 // ramp, Q1.24
    localparam int CURVE_W = 17;                 // curve, Q0.16 up to unity
    localparam int FRAC_W  = 8;                  // interpolation fraction
    localparam int EXP_N   = 1 << EXP_TABLE_BITS;
    localparam int IDX_W   = EXP_TABLE_BITS + 1;
    localparam int PROD_W  = 2 * CURVE_W;
    localparam int SCALE_W = SAMPLE_WIDTH + CURVE_W + 1;

    localparam logic [GAIN_W-1:0]  UNITY_Q24  = GAIN_W'(1 << 24);
    localparam logic [CURVE_W-1:0] UNITY_Q16  = CURVE_W'(1 << 16);
    localparam logic [GAIN_W-1:0]  STEP_RESET = GAIN_W'(32768);

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DISC = 2'd0,
        CFG_END_DISC   = 2'd1,
        CFG_FADE_STEP  = 2'd2
    } cfg_reg_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic mix_en;
        logic scale_en;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_full;
    } ctrl_status_t;

    // 2^x - 1 table, Q0.16, EXP_N + 1 entries
    typedef logic [CURVE_W-1:0] exp_table_t [EXP_N+1];

    localparam longint unsigned Q28_ONE = 64'd268435456;
    localparam longint unsigned LN2_Q28 = 64'd186065280;
    localparam int              EXP_TERMS = 12;

    // Evaluated at elaboration only: Taylor series of e^(x ln2), Q4.28,
    // rounded to Q0.16 and forced nondecreasing.
    function automatic exp_table_t build_exp_table();
        exp_table_t      t;
        longint unsigned x;
        longint unsigned y;
        longint unsigned sum;
        longint unsigned v;
        longint unsigned prev;
        prev = 64'd0;
        for (int i = 0; i <= EXP_N; i++)
        begin
            x   = (64'(i) << 28) >> EXP_TABLE_BITS;
            y   = (x * LN2_Q28) >> 28;
            sum = Q28_ONE;
            for (int k = EXP_TERMS; k >= 1; k--)
            begin
                sum = Q28_ONE + ((y * sum) >> 28) / 64'(k);
            end
            v = (sum > Q28_ONE) ? ((sum - Q28_ONE + 64'd2048) >> 12) : 64'd0;
            if (v > 64'd65536)
            begin
                v = 64'd65536;
            end
            if (i == 0)
            begin
                v = 64'd0;
            end
            if (i == EXP_N)
            begin
                v = 64'd65536;
            end
            if (v < prev)
            begin
                v = prev;
            end
            t[i] = CURVE_W'(v);
            prev = v;
        end
        return t;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

// ===== src/afe_if.sv =====
// ============================================================================
// afe_if
// Valid/ready stream channels for input samples and faded results.
// ============================================================================
`default_nettype none

interface afe_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [afe_pkg::SAMPLE_WIDTH-1:0] sample_in;
    logic                                  ramp_restart;

    modport source (output valid, output sample_in, output ramp_restart, input ready);
    modport sink   (input valid, input sample_in, input ramp_restart, output ready);
endinterface

interface afe_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [afe_pkg::SAMPLE_WIDTH-1:0] sample_out;
    logic [afe_pkg::CURVE_W-1:0]           curve_value;

    modport source (output valid, output sample_out, output curve_value, input ready);
    modport sink   (input valid, input sample_out, input curve_value, output ready);
endinterface

`default_nettype wire

// ===== src/afe_ctrl.sv =====
// ============================================================================
// afe_ctrl
// Sequencer: accept, curve mix, sample scale, result load.
// ============================================================================
`default_nettype none

module afe_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire afe_pkg::ctrl_status_t status,
    output afe_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MIX   = 4'b0010,
        ST_SCALE = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                cmd.mix_en = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // wait here while the previous result is still held
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/afe_datapath.sv =====
// ============================================================================
// afe_datapath
// Config registers, ramp, curve arithmetic, sample scaling, output register.
// ============================================================================
`default_nettype none

module afe_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_we,
    input  wire logic [afe_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [afe_pkg::CFG_DATA_W-1:0]         cfg_data,
    // input payload
    input  wire logic signed [afe_pkg::SAMPLE_WIDTH-1:0] sample_in,
    input  wire logic                                   ramp_restart,
    // output
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [afe_pkg::SAMPLE_WIDTH-1:0]     sample_out,
    output logic [afe_pkg::CURVE_W-1:0]                 curve_value,
    // control
    input  wire afe_pkg::ctrl_cmd_t                     cmd,
    output afe_pkg::ctrl_status_t                       status
);

    localparam int SW      = afe_pkg::SAMPLE_WIDTH;
    localparam int GW      = afe_pkg::GAIN_W;
    localparam int CW      = afe_pkg::CURVE_W;
    localparam int IW      = afe_pkg::IDX_W;
    localparam int FW      = afe_pkg::FRAC_W;
    localparam int PW      = afe_pkg::PROD_W;
    localparam int XW      = afe_pkg::SCALE_W;
    localparam int IDX_LSB = 24 - afe_pkg::EXP_TABLE_BITS;

    // configuration and ramp state
    logic          start_disc_reg;
    logic          end_disc_reg;
    logic [GW-1:0] fade_step_reg;
    logic [GW-1:0] ramp_reg;
    logic [GW-1:0] ramp_next;

    // pipeline registers
    logic signed [SW-1:0] sample_reg;
    logic [CW-1:0]        gq_reg;
    logic [CW-1:0]        base_reg;
    logic [PW-1:0]        prod_reg;
    logic [CW-1:0]        curve_reg;
    logic [CW-1:0]        curve_next;
    logic signed [XW-1:0] scaled_reg;
    logic                 out_valid_reg;
    logic signed [SW-1:0] sample_out_reg;
    logic [CW-1:0]        curve_out_reg;

    // accept-cycle curve terms
    logic [GW-1:0] g_sel;
    logic [CW-1:0] gq;
    logic [IW-1:0] idx;
    logic [IW-1:0] idx_hi;
    logic [FW-1:0] frac;
    logic [CW-1:0] t_lo;
    logic [CW-1:0] t_hi;
    logic [CW-1:0] mul_a;
    logic [CW-1:0] mul_b;
    logic          end_only;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_disc_reg <= 1'b0;
            end_disc_reg   <= 1'b0;
            fade_step_reg  <= afe_pkg::STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                afe_pkg::CFG_START_DISC: start_disc_reg <= cfg_data[0];
                afe_pkg::CFG_END_DISC:   end_disc_reg   <= cfg_data[0];
                afe_pkg::CFG_FADE_STEP:  fade_step_reg  <= cfg_data[GW-1:0];
                default:                 ;
            endcase
        end
    end

    // curve uses the ramp after a restart reload, before this sample's step
    assign g_sel     = ramp_restart ? afe_pkg::UNITY_Q24 : ramp_reg;
    assign ramp_next = (g_sel > fade_step_reg) ? (g_sel - fade_step_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg <= afe_pkg::UNITY_Q24;
        end
        else if (cmd.accept)
        begin
            ramp_reg <= ramp_next;
        end
    end

    assign end_only = end_disc_reg && !start_disc_reg;
    assign gq       = g_sel[GW-1:8];
    assign idx      = g_sel[GW-1:IDX_LSB];
    assign frac     = g_sel[IDX_LSB-1 -: FW];
    assign idx_hi   = (idx >= IW'(afe_pkg::EXP_N)) ? IW'(afe_pkg::EXP_N) : idx + IW'(1);
    assign t_lo     = afe_pkg::EXP_TABLE[idx];
    assign t_hi     = afe_pkg::EXP_TABLE[idx_hi];

    // one shared multiplier: interpolation step or g(1-g)
    assign mul_a = end_only ? (t_hi - t_lo) : gq;
    assign mul_b = end_only ? CW'(frac) : (afe_pkg::UNITY_Q16 - gq);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample_in;
            gq_reg     <= gq;
            base_reg   <= t_lo;
            prod_reg   <= PW'(mul_a) * PW'(mul_b);
        end
    end

    always_comb
    begin
        if (!start_disc_reg && !end_disc_reg)
        begin
            curve_next = afe_pkg::UNITY_Q16;
        end
        else if (start_disc_reg && !end_disc_reg)
        begin
            curve_next = afe_pkg::UNITY_Q16 - gq_reg;
        end
        else if (end_only)
        begin
            curve_next = base_reg + prod_reg[8 +: CW];
        end
        else
        begin
            curve_next = prod_reg[15 +: CW];    // 2*g*(1-g) >> 16
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mix_en)
        begin
            curve_reg <= curve_next;
        end
        if (cmd.scale_en)
        begin
            scaled_reg <= XW'(sample_reg) * XW'($signed({1'b0, curve_reg}));
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= scaled_reg[SW+15:16];  // floor via arithmetic shift
            curve_out_reg  <= curve_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_full = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;
    assign curve_value     = curve_out_reg;

endmodule

`default_nettype wire

// ===== src/audio_fade_envelope_unit.sv =====
// ============================================================================
// audio_fade_envelope_unit
// Fade-in / fade-out envelope applied to a stream of signed audio samples.
// ============================================================================
// Usage:
//  - in_stream carries one sample per transfer plus a restart mark that
//    reloads the Q1.24 ramp to unity on the first sample of a fade region.
//  - out_stream returns the faded sample and the Q0.16 curve applied to it,
//    one result per input, in order.
//  - cfg_we/cfg_index/cfg_data set the start/end discontinuity flags (which
//    pick the curve) and the per-sample ramp step; write only while idle.
// Timing:
//  - An input transfer is followed by its result on out_stream once the
//    controller has run its four steps: accept with table lookup and the
//    shared curve multiply, curve mix, sample-by-curve multiply, output
//    load. A new sample is taken only after the previous one is loaded.
//  - The output register holds a result while the next sample is accepted
//    and processed; if the receiver stalls, the sequencer waits at the load
//    step and in_stream.ready stays low until the result is taken.
// Reset:
//  - rst_n clears the flags, sets the step to 32768 and the ramp to unity.
//    The exponential curve table is a constant; no init sweep is needed.
// ============================================================================
`default_nettype none

module audio_fade_envelope_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    afe_in_if.sink                              in_stream,
    afe_out_if.source                           out_stream,
    input  wire logic                           cfg_we,
    input  wire logic [afe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [afe_pkg::CFG_DATA_W-1:0] cfg_data
);

    afe_pkg::ctrl_cmd_t    cmd;
    afe_pkg::ctrl_status_t status;

    // sequencer owns the input handshake; datapath owns the output register
    afe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_stream.valid),
        .in_ready (in_stream.ready),
        .status   (status),
        .cmd      (cmd)
    );

    afe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_in    (in_stream.sample_in),
        .ramp_restart (in_stream.ramp_restart),
        .out_valid    (out_stream.valid),
        .out_ready    (out_stream.ready),
        .sample_out   (out_stream.sample_out),
        .curve_value  (out_stream.curve_value),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the audio fade envelope unit. A short table of
// directed transfers and register writes walks the curve modes and ramp
// corner cases, then randomized fade regions run under every flag pair and a
// spread of ramp steps. Each result is checked field by field against an
// in-bench envelope predictor, with random gaps on the input and random
// stalls on the output.
// ============================================================================
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import afe_pkg::*;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [CURVE_W-1:0]             curve_t;

    // One input transfer. Rows whose result can be read off by eye carry it
    // in want_s/want_c; everything else is checked against the predictor.
    typedef struct {
        sample_t s;
        bit      restart;
        bit      typed;
        sample_t want_s;
        curve_t  want_c;
    } fade_item_t;

    // One output transfer: faded sample plus the curve that produced it.
    typedef struct {
        sample_t s;
        curve_t  c;
    } faded_t;

    typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
        fade_item_t               item;
    } dir_row_t;

    localparam sample_t S_TOP    = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t S_BOTTOM = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Index 3 decodes to no register; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_IDX = 2'd3;
    localparam logic [CFG_DATA_W-1:0] STEP_ALL_ONES = {CFG_DATA_W{1'b1}};
    localparam logic [CFG_DATA_W-1:0] HALF_STEP     = CFG_DATA_W'(1 << 23);

    localparam int DIR_ROWS     = 37;
    localparam int NUM_PHASES   = 14;
    localparam int PHASE_ITEMS  = 125;
    localparam int HOLD_CYCLES  = 320;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTS   = 30;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    afe_in_if  in_ch ();
    afe_out_if out_ch ();

    audio_fade_envelope_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_ch),
        .out_stream (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: flags, step and ramp as the block should hold them.
    // ------------------------------------------------------------------------
    bit                    start_disc;
    bit                    end_disc;
    logic [CFG_DATA_W-1:0] ramp_step;
    logic [GAIN_W-1:0]     ramp_q24;
    int unsigned           exp2_tab [EXP_N+1];

    fade_item_t feed_q [$];           // waiting to be offered on in_ch
    faded_t     faded_expect_q [$];   // predicted results, oldest first
    int         fed_cnt;
    int         taken_cnt;
    int         err_cnt;
    int         cycle_cnt;
    bit         cfg_busy;

    // 2^x - 1 in Q0.16 at N+1 points: e^(x ln2) by a 12-term Horner series in
    // Q4.28, truncated each step, rounded half up, clamped and monotonic.
    function automatic void build_exp2_tab();
        longint unsigned x;
        longint unsigned y;
        longint unsigned acc;
        longint unsigned v;
        longint unsigned prev;
        prev = 0;
        for (int i = 0; i <= EXP_N; i++)
        begin
            x   = (64'(i) << 28) >> EXP_TABLE_BITS;
            y   = (x * LN2_Q28) >> 28;
            acc = Q28_ONE;
            for (int k = EXP_TERMS; k >= 1; k--)
            begin
                acc = Q28_ONE + ((y * acc) >> 28) / 64'(k);
            end
            v = (acc > Q28_ONE) ? ((acc - Q28_ONE + 64'd2048) >> 12) : 64'd0;
            if (v > 64'd65536)
            begin
                v = 64'd65536;
            end
            if (i == 0)
            begin
                v = 0;
            end
            if (i == EXP_N)
            begin
                v = 64'd65536;
            end
            if (v < prev)
            begin
                v = prev;
            end
            exp2_tab[i] = 32'(v);
            prev = v;
        end
    endfunction

    // Curve from the ramp after any reload and before this sample's step;
    // output is the floor of sample*curve/2^16.
    function automatic void envelope_predict(input sample_t s, input bit restart,
                                             output faded_t res);
        logic [GAIN_W-1:0] g;
        int unsigned       gq;
        int unsigned       idx;
        int unsigned       frac;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       cv;
        longint            prod;
        if (restart)
        begin
            ramp_q24 = UNITY_Q24;
        end
        g  = (ramp_q24 > UNITY_Q24) ? UNITY_Q24 : ramp_q24;
        gq = 32'(g >> 8);
        if (!start_disc && !end_disc)
        begin
            cv = 32'(UNITY_Q16);
        end
        else if (start_disc && !end_disc)
        begin
            cv = 32'(UNITY_Q16) - gq;
        end
        else if (!start_disc && end_disc)
        begin
            idx  = 32'(g) >> (24 - EXP_TABLE_BITS);
            frac = (32'(g) >> (16 - EXP_TABLE_BITS)) & 32'd255;
            if (idx >= EXP_N)
            begin
                cv = exp2_tab[EXP_N];
            end
            else
            begin
                lo = exp2_tab[idx];
                hi = exp2_tab[idx + 1];
                cv = lo + (((hi - lo) * frac) >> 8);
            end
        end
        else
        begin
            cv = 32'((64'd2 * 64'(gq) * (64'(UNITY_Q16) - 64'(gq))) >> 16);
        end
        prod  = longint'(s) * longint'(cv);
        res.s = sample_t'(prod >>> 16);
        res.c = curve_t'(cv);
        if (ramp_q24 > ramp_step)
        begin
            ramp_q24 = ramp_q24 - GAIN_W'(ramp_step);
        end
        else
        begin
            ramp_q24 = '0;
        end
    endfunction

    function automatic fade_item_t plain_item(sample_t s, bit restart);
        fade_item_t it;
        it.s       = s;
        it.restart = restart;
        it.typed   = 1'b0;
        it.want_s  = '0;
        it.want_c  = '0;
        return it;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        r.item = plain_item('0, 1'b0);
        return r;
    endfunction

    function automatic dir_row_t item_row(sample_t s, bit restart);
        dir_row_t r;
        r.kind = ROW_ITEM;
        r.idx  = '0;
        r.data = '0;
        r.item = plain_item(s, restart);
        return r;
    endfunction

    function automatic dir_row_t known_row(sample_t s, bit restart,
                                           sample_t ws, curve_t wc);
        dir_row_t r;
        r = item_row(s, restart);
        r.item.typed  = 1'b1;
        r.item.want_s = ws;
        r.item.want_c = wc;
        return r;
    endfunction

    // Directed table. Register writes wait for the block to drain first.
    dir_row_t dir_tab [DIR_ROWS] = '{
        // after reset: no flags, pass-through at the sample extremes
        known_row(S_TOP,    1'b1, S_TOP,    UNITY_Q16),
        known_row(S_BOTTOM, 1'b0, S_BOTTOM, UNITY_Q16),
        known_row('0,       1'b0, '0,       UNITY_Q16),
        known_row(-1,       1'b0, -1,       UNITY_Q16),
        // fade-in: unity ramp gives a zero curve
        cfg_row(CFG_START_DISC, 1),
        known_row(S_TOP,    1'b1, '0, '0),
        item_row(S_BOTTOM,  1'b0),
        item_row(-1,        1'b0),
        // both flags: 2g(1-g) is zero at unity
        cfg_row(CFG_END_DISC, 1),
        known_row(S_BOTTOM, 1'b1, '0, '0),
        item_row(12345,     1'b0),
        item_row(S_TOP,     1'b0),
        // end only: exponential table, last entry at unity
        cfg_row(CFG_START_DISC, 0),
        known_row(S_BOTTOM, 1'b1, S_BOTTOM, UNITY_Q16),
        item_row(4660,      1'b0),
        // half step: table midpoint, then the ramp sits at zero
        cfg_row(CFG_FADE_STEP, HALF_STEP),
        known_row(S_TOP,    1'b1, S_TOP, UNITY_Q16),
        item_row(S_TOP,     1'b0),
        known_row(S_BOTTOM, 1'b0, '0, '0),
        // step above unity: zero after a single sample
        cfg_row(CFG_FADE_STEP, STEP_ALL_ONES),
        known_row(100,      1'b1, 100, UNITY_Q16),
        known_row(100,      1'b0, '0,  '0),
        // zero step: ramp holds
        cfg_row(CFG_FADE_STEP, 0),
        known_row(-5,       1'b1, -5, UNITY_Q16),
        known_row(-5,       1'b0, -5, UNITY_Q16),
        cfg_row(CFG_START_DISC, 1),
        known_row(7,        1'b0, '0, '0),
        // spare index dropped; flag data masked to bit 0
        cfg_row(CFG_FADE_STEP, 1),
        cfg_row(CFG_SPARE_IDX, STEP_ALL_ONES),
        cfg_row(CFG_START_DISC, 2),
        cfg_row(CFG_END_DISC, STEP_ALL_ONES - 1),
        known_row(S_TOP,    1'b1, S_TOP, UNITY_Q16),
        known_row(-1,       1'b0, -1,    UNITY_Q16),
        // fade-in with the smallest step: curve of one, floor toward -inf
        cfg_row(CFG_START_DISC, 1),
        known_row(S_BOTTOM, 1'b1, '0, '0),
        item_row(S_BOTTOM,  1'b0),
        item_row(-1,        1'b0)
    };

    task automatic flag_mismatch(input string what, input longint got,
                                 input longint want);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
        begin
            $display("ERROR %s: got %0d, want %0d (result %0d)",
                     what, got, want, taken_cnt);
        end
    endtask

    function automatic bit drained();
        return (fed_cnt == taken_cnt) && (faded_expect_q.size() == 0);
    endfunction

    task automatic push_item(input fade_item_t it);
        feed_q.push_back(it);
        fed_cnt++;
    endtask

    // One register write per clock; the predictor copy follows at once since
    // writes only happen with the block drained.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_busy   = 1'b1;
        case (idx)
            CFG_START_DISC: start_disc = data[0];
            CFG_END_DISC:   end_disc   = data[0];
            CFG_FADE_STEP:  ramp_step  = data;
            default:        ;
        endcase
    endtask

    task automatic cfg_quiet();
        if (cfg_busy)
        begin
            @(posedge clk);
            cfg_we  <= 1'b0;
            cfg_busy = 1'b0;
        end
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 15))
            0:       return S_TOP;
            1:       return S_BOTTOM;
            2:       return '0;
            3:       return -1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. A transfer
    // seen at an edge is run through the predictor right there, so the
    // expectation is queued before its result can possibly show up.
    // ------------------------------------------------------------------------
    initial
    begin : sender
        fade_item_t cur;
        faded_t     pred;
        int         burst_left;
        int         gap_left;
        in_ch.valid        <= 1'b0;
        in_ch.sample_in    <= '0;
        in_ch.ramp_restart <= 1'b0;
        burst_left = 8;
        gap_left   = 0;
        forever
        begin
            @(posedge clk);
            if (in_ch.valid && in_ch.ready)
            begin
                envelope_predict(cur.s, cur.restart, pred);
                if (cur.typed)
                begin
                    pred.s = cur.want_s;
                    pred.c = cur.want_c;
                end
                faded_expect_q.push_back(pred);
                taken_cnt++;
            end
            // hold an offered item until its transfer completes
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (feed_q.size() > 0)
                begin
                    cur = feed_q.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.sample_in    <= cur.s;
                    in_ch.ramp_restart <= cur.restart;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0
                                                                 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: checks each result against the oldest expectation and picks
    // ready from a mode that is redrawn at random. Twice in the run
    // it holds ready low for a long stretch so the output register fills and
    // in_ch.ready drops while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        faded_t want;
        int     seen_cnt;
        int     hold_left;
        int     rx_mode;
        int     rx_left;
        int     rx_tick;
        bit     rdy;
        out_ch.ready <= 1'b0;
        seen_cnt  = 0;
        hold_left = 0;
        rx_mode   = 0;
        rx_left   = 50;
        rx_tick   = 0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                seen_cnt++;
                if (faded_expect_q.size() == 0)
                begin
                    flag_mismatch("result with nothing expected",
                                  longint'(out_ch.sample_out), 0);
                end
                else
                begin
                    want = faded_expect_q.pop_front();
                    if (out_ch.sample_out !== want.s)
                    begin
                        flag_mismatch("sample_out", longint'(out_ch.sample_out),
                                      longint'(want.s));
                    end
                    if (out_ch.curve_value !== want.c)
                    begin
                        flag_mismatch("curve_value", longint'(out_ch.curve_value),
                                      longint'(want.c));
                    end
                end
                if (seen_cnt == 460 || seen_cnt == 1090)
                begin
                    hold_left = HOLD_CYCLES;
                end
            end
            rx_tick++;
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = ($urandom_range(0, 3) == 0);
                default: rdy = ((rx_tick % 7) < 3);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            out_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("audio_fade_envelope_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random fade regions, wrap-up.
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [CFG_DATA_W-1:0] step;
        int unsigned           fade_len;
        int                    made;
        int                    span;
        rst_n      = 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_START_DISC;
        cfg_data  <= '0;
        cfg_busy   = 1'b0;
        fed_cnt    = 0;
        taken_cnt  = 0;
        err_cnt    = 0;
        build_exp2_tab();
        start_disc = 1'b0;
        end_disc   = 1'b0;
        ramp_step  = STEP_RESET;
        ramp_q24   = UNITY_Q24;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_tab[r].kind == ROW_CFG)
            begin
                while (!drained()) @(posedge clk);
                cfg_write(dir_tab[r].idx, dir_tab[r].data);
            end
            else
            begin
                cfg_quiet();
                push_item(dir_tab[r].item);
            end
        end

        // Random phases: flag pair cycles through all four, step cycles
        // through zero, unity, all ones, one, fully random and fade lengths.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            while (!drained()) @(posedge clk);
            case (ph % 7)
                0:       step = '0;
                1:       step = CFG_DATA_W'(UNITY_Q24);
                2:       step = STEP_ALL_ONES;
                3:       step = CFG_DATA_W'(1);
                4:       step = CFG_DATA_W'($urandom);
                default: step = CFG_DATA_W'(32'(UNITY_Q24) / $urandom_range(2, 160));
            endcase
            // random upper bits on the flag writes check the masking
            cfg_write(CFG_START_DISC, CFG_DATA_W'({$urandom, 1'b0}) | CFG_DATA_W'(ph & 1));
            cfg_write(CFG_END_DISC,
                      CFG_DATA_W'({$urandom, 1'b0}) | CFG_DATA_W'((ph >> 1) & 1));
            cfg_write(CFG_FADE_STEP, step);
            if ($urandom_range(0, 3) == 0)
            begin
                cfg_write(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
            end
            cfg_quiet();

            // fade length in samples, capped so regions stay short
            fade_len = (step == 0) ? 200 : 32'(UNITY_Q24) / 32'(step);
            if (fade_len > 400)
            begin
                fade_len = 400;
            end
            if (fade_len < 1)
            begin
                fade_len = 1;
            end

            // Mostly whole regions (restart then a run past the fade end),
            // with a sprinkle of stray items carrying a random restart bit.
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_item(plain_item(rand_sample(), $urandom_range(0, 1)));
                    made++;
                end
                else
                begin
                    span = $urandom_range(1, fade_len + fade_len / 4 + 4);
                    for (int k = 0; k < span && made < PHASE_ITEMS; k++)
                    begin
                        push_item(plain_item(rand_sample(), k == 0));
                        made++;
                    end
                end
            end
        end

        while (!drained()) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faded_expect_q.size() != 0)
        begin
            flag_mismatch("results never delivered", 0, faded_expect_q.size());
        end
        if (err_cnt == 0)
        begin
            $display("audio_fade_envelope_unit: match");
        end
        else
        begin
            $display("audio_fade_envelope_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
